@@ src/tga_dec_pkg.sv @@
// Shared types and constants for the TGA image stream decoder.
// No dependencies; used by tga_dec_core and tga_image_stream_decoder.
package tga_dec_pkg;

    localparam int PixelCountBits = 32;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_PIXEL  = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_SIG   = 3'd1;
    localparam logic [2:0] ST_BAD_SIZE  = 3'd2;
    localparam logic [2:0] ST_OVERRUN   = 3'd3;
    localparam logic [2:0] ST_TRUNCATED = 3'd4;

    localparam logic [7:0] TYPE_RAW   = 8'd2;
    localparam logic [7:0] TYPE_RLE   = 8'd10;
    localparam logic [7:0] DEPTH_24   = 8'd24;
    localparam logic [7:0] DEPTH_32   = 8'd32;
    localparam logic [7:0] RUN_FLAG   = 8'd128;
    localparam logic [7:0] RUN_BIAS   = 8'd127;

    localparam logic [4:0] IDX_TYPE   = 5'd2;
    localparam logic [4:0] IDX_SIG_END = 5'd12;
    localparam logic [4:0] IDX_W_LO   = 5'd12;
    localparam logic [4:0] IDX_W_HI   = 5'd13;
    localparam logic [4:0] IDX_H_LO   = 5'd14;
    localparam logic [4:0] IDX_H_HI   = 5'd15;
    localparam logic [4:0] IDX_DEPTH  = 5'd16;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [7:0]  repeat_count;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic        has_alpha;
        logic [2:0]  status;
        logic        image_done;
    } t_result;

endpackage

@@ src/tga_dec_core.sv @@
// Decoder state and per-byte step logic: header parse, packet and pixel assembly.
// Depends on tga_dec_pkg.
module tga_dec_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_data,
    input  logic                 i_first,
    input  logic                 i_final,
    output logic                 o_emit,
    output tga_dec_pkg::t_result o_result
);

    localparam logic [2:0] PH_WAIT  = 3'd0;
    localparam logic [2:0] PH_SIG   = 3'd1;
    localparam logic [2:0] PH_HDR   = 3'd2;
    localparam logic [2:0] PH_PKT   = 3'd3;
    localparam logic [2:0] PH_COLOR = 3'd4;
    localparam logic [2:0] PH_END   = 3'd5;

    localparam int PB = tga_dec_pkg::PixelCountBits;

    logic [2:0]    r_phase, n_phase;
    logic [4:0]    r_hdr_idx, n_hdr_idx;
    logic          r_is_comp, n_is_comp;
    logic [15:0]   r_width, n_width;
    logic [15:0]   r_height, n_height;
    logic          r_four, n_four;
    logic [PB-1:0] r_pix_left, n_pix_left;
    logic [7:0]    r_pkt_left, n_pkt_left;
    logic          r_pkt_run, n_pkt_run;
    logic [23:0]   r_color, n_color;
    logic [1:0]    r_color_idx, n_color_idx;

    logic [31:0] prod;
    logic        failed;
    logic [2:0]  fail_st;
    logic        done;
    logic        emit_n;
    logic [1:0]  kind;
    logic [7:0]  px_r, px_g, px_b, px_a, px_cnt;
    logic        last_byte;

    always_comb begin
        n_phase     = r_phase;
        n_hdr_idx   = r_hdr_idx;
        n_is_comp   = r_is_comp;
        n_width     = r_width;
        n_height    = r_height;
        n_four      = r_four;
        n_pix_left  = r_pix_left;
        n_pkt_left  = r_pkt_left;
        n_pkt_run   = r_pkt_run;
        n_color     = r_color;
        n_color_idx = r_color_idx;
        prod        = 32'(r_width) * 32'(r_height);
        failed      = 1'b0;
        fail_st     = tga_dec_pkg::ST_OK;
        done        = 1'b0;
        emit_n      = 1'b0;
        kind        = tga_dec_pkg::KIND_HEADER;
        px_r        = 8'd0;
        px_g        = 8'd0;
        px_b        = 8'd0;
        px_a        = 8'd0;
        px_cnt      = 8'd0;
        last_byte   = 1'b0;

        if (i_first) begin
            n_hdr_idx   = 5'd0;
            n_is_comp   = 1'b0;
            n_width     = 16'd0;
            n_height    = 16'd0;
            n_four      = 1'b0;
            n_pix_left  = '0;
            n_pkt_left  = 8'd0;
            n_pkt_run   = 1'b0;
            n_color     = 24'd0;
            n_color_idx = 2'd0;
            n_phase     = PH_SIG;
        end

        if (n_phase != PH_WAIT && n_phase != PH_END) begin
            last_byte = i_final;
            case (n_phase)
                PH_SIG: begin
                    if (n_hdr_idx == tga_dec_pkg::IDX_TYPE) begin
                        if (i_data == tga_dec_pkg::TYPE_RAW) begin
                            n_is_comp = 1'b0;
                        end else if (i_data == tga_dec_pkg::TYPE_RLE) begin
                            n_is_comp = 1'b1;
                        end else begin
                            failed  = 1'b1;
                            fail_st = tga_dec_pkg::ST_BAD_SIG;
                        end
                    end else if (i_data != 8'd0) begin
                        failed  = 1'b1;
                        fail_st = tga_dec_pkg::ST_BAD_SIG;
                    end
                    if (!failed) begin
                        n_hdr_idx = n_hdr_idx + 5'd1;
                        if (n_hdr_idx >= tga_dec_pkg::IDX_SIG_END) begin
                            n_phase = PH_HDR;
                        end
                    end
                end
                PH_HDR: begin
                    case (r_hdr_idx)
                        tga_dec_pkg::IDX_W_LO: n_width = {8'd0, i_data};
                        tga_dec_pkg::IDX_W_HI: n_width = {i_data, r_width[7:0]};
                        tga_dec_pkg::IDX_H_LO: n_height = {8'd0, i_data};
                        tga_dec_pkg::IDX_H_HI: n_height = {i_data, r_height[7:0]};
                        tga_dec_pkg::IDX_DEPTH: begin
                            if (r_width == 16'd0 || r_height == 16'd0 ||
                                (i_data != tga_dec_pkg::DEPTH_24 &&
                                 i_data != tga_dec_pkg::DEPTH_32)) begin
                                failed  = 1'b1;
                                fail_st = tga_dec_pkg::ST_BAD_SIZE;
                            end else begin
                                n_four = (i_data == tga_dec_pkg::DEPTH_32);
                                if ((prod >> PB) != 32'd0) begin
                                    n_pix_left = '1;
                                end else begin
                                    n_pix_left = prod[PB-1:0];
                                end
                            end
                        end
                        default: begin
                            n_color_idx = 2'd0;
                            n_phase     = r_is_comp ? PH_PKT : PH_COLOR;
                            emit_n      = 1'b1;
                            kind        = tga_dec_pkg::KIND_HEADER;
                        end
                    endcase
                    n_hdr_idx = r_hdr_idx + 5'd1;
                end
                PH_PKT: begin
                    if (i_data < tga_dec_pkg::RUN_FLAG) begin
                        n_pkt_left = i_data + 8'd1;
                        n_pkt_run  = 1'b0;
                    end else begin
                        n_pkt_left = i_data - tga_dec_pkg::RUN_BIAS;
                        n_pkt_run  = 1'b1;
                    end
                    n_color_idx = 2'd0;
                    n_phase     = PH_COLOR;
                end
                default: begin
                    if ((!r_four && r_color_idx < 2'd2) ||
                        (r_four && r_color_idx < 2'd3)) begin
                        case (r_color_idx)
                            2'd0:    n_color = {r_color[23:8], i_data};
                            2'd1:    n_color = {r_color[23:16], i_data, r_color[7:0]};
                            default: n_color = {i_data, r_color[15:0]};
                        endcase
                        n_color_idx = r_color_idx + 2'd1;
                    end else begin
                        px_b        = r_color[7:0];
                        px_g        = r_color[15:8];
                        px_r        = r_four ? r_color[23:16] : i_data;
                        px_a        = r_four ? i_data : 8'd0;
                        n_color     = 24'd0;
                        n_color_idx = 2'd0;
                        px_cnt      = 8'd1;
                        if (!r_is_comp) begin
                            if (r_pix_left == '0) begin
                                failed  = 1'b1;
                                fail_st = tga_dec_pkg::ST_OVERRUN;
                            end else begin
                                n_pix_left = r_pix_left - PB'(1);
                                done       = (n_pix_left == '0);
                            end
                        end else if (r_pkt_run) begin
                            px_cnt = r_pkt_left;
                            if (PB'(r_pkt_left) > r_pix_left) begin
                                failed  = 1'b1;
                                fail_st = tga_dec_pkg::ST_OVERRUN;
                            end else begin
                                n_pix_left = r_pix_left - PB'(r_pkt_left);
                                n_pkt_left = 8'd0;
                                done       = (n_pix_left == '0);
                                n_phase    = PH_PKT;
                            end
                        end else begin
                            if (r_pix_left == '0) begin
                                failed  = 1'b1;
                                fail_st = tga_dec_pkg::ST_OVERRUN;
                            end else begin
                                n_pix_left = r_pix_left - PB'(1);
                                n_pkt_left = r_pkt_left - 8'd1;
                                done       = (n_pix_left == '0) && (n_pkt_left == 8'd0);
                                n_phase    = (n_pkt_left == 8'd0) ? PH_PKT : PH_COLOR;
                            end
                        end
                        if (!failed) begin
                            if (done) begin
                                n_phase = PH_END;
                            end
                            emit_n = 1'b1;
                            kind   = tga_dec_pkg::KIND_PIXEL;
                        end
                    end
                end
            endcase

            if (!failed && last_byte && !done) begin
                failed  = 1'b1;
                fail_st = tga_dec_pkg::ST_TRUNCATED;
            end
            if (failed) begin
                n_phase = PH_END;
                emit_n  = 1'b1;
                kind    = tga_dec_pkg::KIND_ERROR;
            end
        end

        o_emit = emit_n;
        o_result.result_kind  = kind;
        o_result.image_width  = n_width;
        o_result.image_height = n_height;
        o_result.has_alpha    = n_four;
        if (kind == tga_dec_pkg::KIND_PIXEL) begin
            o_result.red          = px_r;
            o_result.green        = px_g;
            o_result.blue         = px_b;
            o_result.alpha        = px_a;
            o_result.repeat_count = px_cnt;
        end else begin
            o_result.red          = 8'd0;
            o_result.green        = 8'd0;
            o_result.blue         = 8'd0;
            o_result.alpha        = 8'd0;
            o_result.repeat_count = 8'd0;
        end
        o_result.status     = failed ? fail_st : tga_dec_pkg::ST_OK;
        o_result.image_done = failed ? 1'b1 : done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_WAIT;
            r_hdr_idx   <= 5'd0;
            r_is_comp   <= 1'b0;
            r_width     <= 16'd0;
            r_height    <= 16'd0;
            r_four      <= 1'b0;
            r_pix_left  <= '0;
            r_pkt_left  <= 8'd0;
            r_pkt_run   <= 1'b0;
            r_color     <= 24'd0;
            r_color_idx <= 2'd0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_hdr_idx   <= n_hdr_idx;
            r_is_comp   <= n_is_comp;
            r_width     <= n_width;
            r_height    <= n_height;
            r_four      <= n_four;
            r_pix_left  <= n_pix_left;
            r_pkt_left  <= n_pkt_left;
            r_pkt_run   <= n_pkt_run;
            r_color     <= n_color;
            r_color_idx <= n_color_idx;
        end
    end

endmodule

@@ src/tga_image_stream_decoder.sv @@
// Top level of the TGA image stream decoder: input register, result register.
// Depends on tga_dec_pkg and tga_dec_core.
//
// Usage: feed the file one byte per transaction on the input channel
// (i_valid / o_stall), with i_first_byte on the first signature byte of each
// file and i_final_byte on the last byte available. Results leave on the
// output channel (o_valid / i_stall): a header transaction after the
// descriptor byte, one pixel transaction per color (with repeat count) and
// an error transaction on a bad signature, bad size or depth, overrun or
// truncation. o_image_done marks the transaction that ends the image.
// Throughput: one byte per cycle while the receiver does not stall; bytes
// that produce no result still take one slot in the input register. The
// path is input register, decode logic and state update, result register.
// Reset clears the valid bits of both registers and returns the decoder to waiting for a new
// file; bytes without i_first_byte are then dropped silently.
// When the receiver stalls, the result register holds and the input
// register fills; o_stall then rises until the result is taken.
module tga_image_stream_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    input  logic        i_final_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_result_kind,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_alpha,
    output logic [7:0]  o_repeat_count,
    output logic [15:0] o_image_width,
    output logic [15:0] o_image_height,
    output logic        o_has_alpha,
    output logic [2:0]  o_status,
    output logic        o_image_done
);

    logic                 r_in_valid;
    logic [7:0]           r_in_data;
    logic                 r_in_first;
    logic                 r_in_final;
    logic                 r_out_valid;
    tga_dec_pkg::t_result r_out;

    logic                 advance;
    logic                 step;
    logic                 emit;
    tga_dec_pkg::t_result result;

    assign advance = !r_out_valid || !i_stall;
    assign step    = r_in_valid && advance;
    assign o_stall = r_in_valid && !advance;

    tga_dec_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_data   (r_in_data),
        .i_first  (r_in_first),
        .i_final  (r_in_final),
        .o_emit   (emit),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_in_data  <= i_data_byte;
            r_in_first <= i_first_byte;
            r_in_final <= i_final_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= step && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_result_kind  = r_out.result_kind;
    assign o_red          = r_out.red;
    assign o_green        = r_out.green;
    assign o_blue         = r_out.blue;
    assign o_alpha        = r_out.alpha;
    assign o_repeat_count = r_out.repeat_count;
    assign o_image_width  = r_out.image_width;
    assign o_image_height = r_out.image_height;
    assign o_has_alpha    = r_out.has_alpha;
    assign o_status       = r_out.status;
    assign o_image_done   = r_out.image_done;

endmodule

@@ tb/tga_dec_checker.sv @@
// Scoreboard for the TGA image stream decoder: watches both channels, predicts
// every result from the accepted bytes and compares field by field.
// Depends on tga_dec_pkg.
`timescale 1ns / 1ps
module tga_dec_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_first_byte,
    input  logic                 i_final_byte,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  tga_dec_pkg::t_result i_result,
    output int                   o_mismatches,
    output int                   o_pending,
    output int                   o_checked
);

    typedef enum logic [2:0] {
        DEC_IDLE, DEC_SIGNATURE, DEC_HEADER, DEC_PACKET, DEC_COLOR, DEC_DONE
    } t_dec_stage;

    t_dec_stage  stage;
    logic [4:0]  hdr_pos;
    logic        rle_mode;
    logic [15:0] width_q;
    logic [15:0] height_q;
    logic        rgba_mode;
    logic [31:0] pixels_due;
    logic [7:0]  packet_due;
    logic        packet_repeats;
    logic [23:0] color_acc;
    logic [1:0]  color_pos;

    tga_dec_pkg::t_result expected_q[$];
    int      mismatch_n = 0;
    int      pending_n = 0;
    int      checked_n = 0;

    assign o_mismatches = mismatch_n;
    assign o_pending    = pending_n;
    assign o_checked    = checked_n;

    function automatic void clear_image();
        hdr_pos        = '0;
        rle_mode       = 1'b0;
        width_q        = '0;
        height_q       = '0;
        rgba_mode      = 1'b0;
        pixels_due     = '0;
        packet_due     = '0;
        packet_repeats = 1'b0;
        color_acc      = '0;
        color_pos      = '0;
    endfunction

    function automatic tga_dec_pkg::t_result make_result(input logic [1:0] kind,
                                            input logic [7:0] r,
                                            input logic [7:0] g, input logic [7:0] b,
                                            input logic [7:0] a, input logic [7:0] cnt,
                                            input logic [2:0] st, input logic done);
        tga_dec_pkg::t_result x;
        x.result_kind  = kind;
        x.red          = r;
        x.green        = g;
        x.blue         = b;
        x.alpha        = a;
        x.repeat_count = cnt;
        x.image_width  = width_q;
        x.image_height = height_q;
        x.has_alpha    = rgba_mode;
        x.status       = st;
        x.image_done   = done;
        return x;
    endfunction

    function automatic bit abort_image(input logic [2:0] st,
                                       output tga_dec_pkg::t_result res);
        stage = DEC_DONE;
        res = make_result(tga_dec_pkg::KIND_ERROR, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, st,
                          1'b1);
        return 1'b1;
    endfunction

    function automatic bit decode_byte(input logic [7:0] d, input logic first,
                                       input logic last,
                                       output tga_dec_pkg::t_result res);
        bit         produced;
        bit         done;
        logic [7:0] r, g, b, a, cnt;
        logic [1:0] last_pos;
        produced = 1'b0;
        done = 1'b0;
        if (first) begin
            clear_image();
            stage = DEC_SIGNATURE;
        end
        if (stage == DEC_IDLE || stage == DEC_DONE)
            return 1'b0;
        case (stage)
            DEC_SIGNATURE: begin
                if (hdr_pos == tga_dec_pkg::IDX_TYPE) begin
                    if (d == tga_dec_pkg::TYPE_RAW)
                        rle_mode = 1'b0;
                    else if (d == tga_dec_pkg::TYPE_RLE)
                        rle_mode = 1'b1;
                    else
                        return abort_image(tga_dec_pkg::ST_BAD_SIG, res);
                end else if (d != 8'd0) begin
                    return abort_image(tga_dec_pkg::ST_BAD_SIG, res);
                end
                hdr_pos = hdr_pos + 5'd1;
                if (hdr_pos >= tga_dec_pkg::IDX_SIG_END)
                    stage = DEC_HEADER;
            end
            DEC_HEADER: begin
                case (hdr_pos)
                    tga_dec_pkg::IDX_W_LO: width_q = {8'd0, d};
                    tga_dec_pkg::IDX_W_HI: width_q[15:8] = d;
                    tga_dec_pkg::IDX_H_LO: height_q = {8'd0, d};
                    tga_dec_pkg::IDX_H_HI: height_q[15:8] = d;
                    tga_dec_pkg::IDX_DEPTH: begin
                        if (width_q == 16'd0 || height_q == 16'd0 ||
                            (d != tga_dec_pkg::DEPTH_24 && d != tga_dec_pkg::DEPTH_32))
                            return abort_image(tga_dec_pkg::ST_BAD_SIZE, res);
                        rgba_mode = (d == tga_dec_pkg::DEPTH_32);
                        pixels_due = {16'd0, width_q} * {16'd0, height_q};
                    end
                    default: begin
                        color_pos = '0;
                        stage = rle_mode ? DEC_PACKET : DEC_COLOR;
                        res = make_result(tga_dec_pkg::KIND_HEADER, 8'd0, 8'd0, 8'd0,
                                          8'd0, 8'd0, tga_dec_pkg::ST_OK, 1'b0);
                        produced = 1'b1;
                    end
                endcase
                hdr_pos = hdr_pos + 5'd1;
            end
            DEC_PACKET: begin
                if (d < tga_dec_pkg::RUN_FLAG) begin
                    packet_due = d + 8'd1;
                    packet_repeats = 1'b0;
                end else begin
                    packet_due = d - tga_dec_pkg::RUN_BIAS;
                    packet_repeats = 1'b1;
                end
                color_pos = '0;
                stage = DEC_COLOR;
            end
            DEC_COLOR: begin
                last_pos = rgba_mode ? 2'd3 : 2'd2;
                if (color_pos != last_pos) begin
                    color_acc[8*color_pos +: 8] = d;
                    color_pos = color_pos + 2'd1;
                end else begin
                    b = color_acc[7:0];
                    g = color_acc[15:8];
                    if (rgba_mode) begin
                        r = color_acc[23:16];
                        a = d;
                    end else begin
                        r = d;
                        a = 8'd0;
                    end
                    color_acc = '0;
                    color_pos = '0;
                    if (!rle_mode) begin
                        cnt = 8'd1;
                        if (pixels_due == 32'd0)
                            return abort_image(tga_dec_pkg::ST_OVERRUN, res);
                        pixels_due = pixels_due - 32'd1;
                        done = (pixels_due == 32'd0);
                    end else if (packet_repeats) begin
                        cnt = packet_due;
                        if ({24'd0, packet_due} > pixels_due)
                            return abort_image(tga_dec_pkg::ST_OVERRUN, res);
                        pixels_due = pixels_due - {24'd0, packet_due};
                        packet_due = '0;
                        done = (pixels_due == 32'd0);
                        stage = DEC_PACKET;
                    end else begin
                        cnt = 8'd1;
                        if (pixels_due == 32'd0)
                            return abort_image(tga_dec_pkg::ST_OVERRUN, res);
                        pixels_due = pixels_due - 32'd1;
                        packet_due = packet_due - 8'd1;
                        done = (pixels_due == 32'd0 && packet_due == 8'd0);
                        stage = (packet_due == 8'd0) ? DEC_PACKET : DEC_COLOR;
                    end
                    if (done)
                        stage = DEC_DONE;
                    res = make_result(tga_dec_pkg::KIND_PIXEL, r, g, b, a, cnt,
                                      tga_dec_pkg::ST_OK, done);
                    produced = 1'b1;
                end
            end
            default: ;
        endcase
        if (last && !done)
            return abort_image(tga_dec_pkg::ST_TRUNCATED, res);
        return produced;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            mismatch_n++;
            if (mismatch_n <= 10)
                $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, name,
                         want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        tga_dec_pkg::t_result want;
        tga_dec_pkg::t_result got;
        if (!i_rst_n) begin
            stage = DEC_IDLE;
            clear_image();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                if (decode_byte(i_data_byte, i_first_byte, i_final_byte, want))
                    expected_q.push_back(want);
            end
            if (i_out_valid && !i_out_stall) begin
                got = i_result;
                if (expected_q.size() == 0) begin
                    mismatch_n++;
                    if (mismatch_n <= 10)
                        $display("%0t: unexpected transaction, kind %0d status %0d",
                                 $realtime, got.result_kind, got.status);
                end else begin
                    want = expected_q.pop_front();
                    checked_n++;
                    check_field("result_kind", 32'(want.result_kind),
                                32'(got.result_kind));
                    check_field("red", 32'(want.red), 32'(got.red));
                    check_field("green", 32'(want.green), 32'(got.green));
                    check_field("blue", 32'(want.blue), 32'(got.blue));
                    check_field("alpha", 32'(want.alpha), 32'(got.alpha));
                    check_field("repeat_count", 32'(want.repeat_count),
                                32'(got.repeat_count));
                    check_field("image_width", 32'(want.image_width),
                                32'(got.image_width));
                    check_field("image_height", 32'(want.image_height),
                                32'(got.image_height));
                    check_field("has_alpha", 32'(want.has_alpha), 32'(got.has_alpha));
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("image_done", 32'(want.image_done),
                                32'(got.image_done));
                end
            end
            pending_n = expected_q.size();
        end
    end

endmodule

@@ tb/tb_top.sv @@
// Top of the TGA decoder testbench: clock, reset, byte stream and receiver stalls.
// Instantiates tga_image_stream_decoder and tga_dec_checker; uses tga_dec_pkg.
`timescale 1ns / 1ps
module tb_top;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_data_byte = '0;
    logic        i_first_byte = 1'b0;
    logic        i_final_byte = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_result_kind;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic [7:0]  o_alpha;
    logic [7:0]  o_repeat_count;
    logic [15:0] o_image_width;
    logic [15:0] o_image_height;
    logic        o_has_alpha;
    logic [2:0]  o_status;
    logic        o_image_done;

    tga_dec_pkg::t_result dut_result;
    int          mismatches;
    int          pending;
    int          checked;

    logic [7:0]  file_q[$];
    int          bytes_sent = 0;
    int          files_sent = 0;
    bit          calm = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    tga_image_stream_decoder i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_data_byte    (i_data_byte),
        .i_first_byte   (i_first_byte),
        .i_final_byte   (i_final_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result_kind  (o_result_kind),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_alpha        (o_alpha),
        .o_repeat_count (o_repeat_count),
        .o_image_width  (o_image_width),
        .o_image_height (o_image_height),
        .o_has_alpha    (o_has_alpha),
        .o_status       (o_status),
        .o_image_done   (o_image_done)
    );

    assign dut_result = {o_result_kind, o_red, o_green, o_blue, o_alpha, o_repeat_count,
                         o_image_width, o_image_height, o_has_alpha, o_status, o_image_done};

    tga_dec_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_data_byte  (i_data_byte),
        .i_first_byte (i_first_byte),
        .i_final_byte (i_final_byte),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_result     (dut_result),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always @(negedge i_clk) begin
        i_stall <= i_rst_n && !calm && ($urandom_range(0, 99) < 6);
    end

    task automatic put_byte(input logic [7:0] d, input logic first, input logic last);
        if (!calm && $urandom_range(0, 99) < 6) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_byte <= d;
        i_first_byte <= first;
        i_final_byte <= last;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_file(input bit with_final);
        for (int i = 0; i < file_q.size(); i++)
            put_byte(file_q[i], i == 0, with_final && i == file_q.size() - 1);
        files_sent++;
    endtask

    task automatic put_header(input logic [7:0] img_type, input logic [15:0] w,
                              input logic [15:0] h, input logic [7:0] depth);
        file_q.delete();
        for (int i = 0; i < 12; i++)
            file_q.push_back(i == tga_dec_pkg::IDX_TYPE ? img_type : 8'd0);
        file_q.push_back(w[7:0]);
        file_q.push_back(w[15:8]);
        file_q.push_back(h[7:0]);
        file_q.push_back(h[15:8]);
        file_q.push_back(depth);
        file_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic put_color(input bit rgba);
        repeat (rgba ? 4 : 3) file_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic build_random_file(output bit with_final);
        int          sel;
        int          k;
        int          n;
        int          top;
        int          remaining;
        int          cut;
        bit          rle;
        bit          rgba;
        logic [15:0] w;
        logic [15:0] h;
        logic [7:0]  v;
        sel = $urandom_range(0, 99);
        rle = 1'($urandom_range(0, 1));
        rgba = 1'($urandom_range(0, 1));
        w = 16'($urandom_range(1, 4));
        h = 16'($urandom_range(1, 3));
        if (sel < 8) begin
            w = 16'($urandom_range(1, 16'hFFFF));
            h = 16'($urandom_range(1, 16'hFFFF));
        end else if (sel < 16 && rle) begin
            w = 16'd16;
            h = 16'($urandom_range(8, 16));
        end
        put_header(rle ? tga_dec_pkg::TYPE_RLE : tga_dec_pkg::TYPE_RAW, w, h,
                   rgba ? tga_dec_pkg::DEPTH_32 : tga_dec_pkg::DEPTH_24);
        with_final = 1'($urandom_range(0, 1));
        if (sel >= 90) begin
            k = $urandom_range(0, 16);
            if (k == tga_dec_pkg::IDX_TYPE) begin
                do v = 8'($urandom_range(0, 255));
                while (v == tga_dec_pkg::TYPE_RAW || v == tga_dec_pkg::TYPE_RLE);
                file_q[k] = v;
            end else if (k < tga_dec_pkg::IDX_SIG_END) begin
                file_q[k] = 8'($urandom_range(1, 255));
            end else if (k <= tga_dec_pkg::IDX_W_HI) begin
                file_q[tga_dec_pkg::IDX_W_LO] = 8'd0;
                file_q[tga_dec_pkg::IDX_W_HI] = 8'd0;
            end else if (k <= tga_dec_pkg::IDX_H_HI) begin
                file_q[tga_dec_pkg::IDX_H_LO] = 8'd0;
                file_q[tga_dec_pkg::IDX_H_HI] = 8'd0;
            end else begin
                do v = 8'($urandom_range(0, 255));
                while (v == tga_dec_pkg::DEPTH_24 || v == tga_dec_pkg::DEPTH_32);
                file_q[tga_dec_pkg::IDX_DEPTH] = v;
            end
            return;
        end
        remaining = (sel < 8) ? 1 << 30 : int'(w) * int'(h);
        while (remaining > 0 && file_q.size() < 18 + ((sel < 8) ? 40 : 200)) begin
            if (!rle) begin
                put_color(rgba);
                remaining--;
            end else begin
                top = remaining > 128 ? 128 : remaining;
                if ((sel < 16 || $urandom_range(0, 1)) && !(sel >= 85 && sel < 90)) begin
                    n = (sel < 16 && $urandom_range(0, 3) != 0) ? top : $urandom_range(1, top);
                    file_q.push_back(8'(int'(tga_dec_pkg::RUN_BIAS) + n));
                    put_color(rgba);
                end else begin
                    n = $urandom_range(1, (sel >= 85 && sel < 90) ? 4 : (top > 4 ? 4 : top));
                    file_q.push_back(8'(n - 1));
                    repeat (n) put_color(rgba);
                end
                remaining -= n;
            end
        end
        if (rle && sel >= 80 && sel < 85) begin
            file_q.push_back(8'($urandom_range(tga_dec_pkg::RUN_FLAG, 255)));
            put_color(rgba);
        end
        if (sel >= 16 && sel < 34) begin
            cut = $urandom_range(1, file_q.size() - 1);
            while (file_q.size() > cut) void'(file_q.pop_back());
            with_final = (sel < 28);
        end
    endtask

    initial begin : stimulus
        bit with_final;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // stray bytes before any file
        put_byte(8'hFF, 1'b0, 1'b0);
        put_byte(8'h00, 1'b0, 1'b1);
        // bad signature on the first byte and on the type byte
        file_q.delete();
        file_q.push_back(8'hFF);
        send_file(1'b0);
        file_q.delete();
        file_q.push_back(8'h00);
        file_q.push_back(8'h00);
        file_q.push_back(8'h03);
        send_file(1'b0);
        put_byte(8'h55, 1'b0, 1'b0);
        // smallest uncompressed image, final on its last byte
        put_header(tga_dec_pkg::TYPE_RAW, 16'd1, 16'd1, tga_dec_pkg::DEPTH_24);
        put_color(1'b0);
        send_file(1'b1);
        // largest size, longest run, then truncation
        put_header(tga_dec_pkg::TYPE_RLE, 16'hFFFF, 16'hFFFF, tga_dec_pkg::DEPTH_32);
        file_q.push_back(8'hFF);
        put_color(1'b1);
        send_file(1'b1);
        // raw packet of 128 into a one-pixel image
        put_header(tga_dec_pkg::TYPE_RLE, 16'd1, 16'd1, tga_dec_pkg::DEPTH_24);
        file_q.push_back(tga_dec_pkg::RUN_BIAS);
        put_color(1'b0);
        put_color(1'b0);
        send_file(1'b0);
        // run longer than the image
        put_header(tga_dec_pkg::TYPE_RLE, 16'd1, 16'd1, tga_dec_pkg::DEPTH_32);
        file_q.push_back(8'h81);
        put_color(1'b1);
        send_file(1'b0);
        // zero width, bad depth
        put_header(tga_dec_pkg::TYPE_RAW, 16'd0, 16'd1, tga_dec_pkg::DEPTH_24);
        send_file(1'b0);
        put_header(tga_dec_pkg::TYPE_RAW, 16'd1, 16'd1, 8'd33);
        send_file(1'b0);
        // final on the descriptor byte
        put_header(tga_dec_pkg::TYPE_RAW, 16'd2, 16'd2, tga_dec_pkg::DEPTH_32);
        send_file(1'b1);
        // complete 32-bit image with a trailing byte dropped
        put_header(tga_dec_pkg::TYPE_RAW, 16'd2, 16'd1, tga_dec_pkg::DEPTH_32);
        put_color(1'b1);
        put_color(1'b1);
        file_q.push_back(8'hA5);
        send_file(1'b0);

        while (bytes_sent < 650) begin
            calm = (bytes_sent >= 250 && bytes_sent < 420);
            if ($urandom_range(0, 99) < 5)
                put_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
            build_random_file(with_final);
            send_file(with_final);
        end
        calm = 1'b0;
        i_valid <= 1'b0;

        wait (pending == 0);
        repeat (10) @(posedge i_clk);
        $display("Sent %0d bytes in %0d files; %0d results checked, %0d mismatches.",
                 bytes_sent, files_sent, checked, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #1000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

@@ sim.f @@
src/tga_dec_pkg.sv
src/tga_dec_core.sv
src/tga_image_stream_decoder.sv
tb/tga_dec_checker.sv
tb/tb_top.sv
